### hdl/ftc_pkg.sv
// Shared types, constants and helpers for the floor texture caster.
package ftc_pkg;

  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int PROD_W  = 49;
  localparam int DIV_W   = 28;
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd49;

  localparam logic [CIDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CIDX_W-1:0] REG_PLANE_Y = 3'd5;

  localparam logic [15:0] DIR_X_RST   = 16'd16384;
  localparam logic [15:0] PLANE_Y_RST = 16'd10813;

  localparam logic [1:0] AX_FX = 2'd0;
  localparam logic [1:0] AX_FY = 2'd1;
  localparam logic [1:0] AX_SX = 2'd2;
  localparam logic [1:0] AX_SY = 2'd3;

  typedef logic [3:0] ftc_op_t;
  localparam ftc_op_t OP_NONE       = 4'd0;
  localparam ftc_op_t OP_ACCEPT     = 4'd1;
  localparam ftc_op_t OP_RD_FIX     = 4'd2;
  localparam ftc_op_t OP_MUL        = 4'd3;
  localparam ftc_op_t OP_FP_FIX     = 4'd4;
  localparam ftc_op_t OP_SDIV_START = 4'd5;
  localparam ftc_op_t OP_STEP_FIX   = 4'd6;
  localparam ftc_op_t OP_FETCH      = 4'd7;
  localparam ftc_op_t OP_OUT        = 4'd8;

  typedef struct packed {
    logic        operation;
    logic [13:0] texel_index;
    logic [23:0] texel_color;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
  } ftc_in_t;

  typedef struct packed {
    logic [9:0]  out_x;
    logic [8:0]  out_y;
    logic [22:0] out_color;
  } ftc_out_t;

  typedef struct packed {
    ftc_op_t    op;
    logic [1:0] axis;
  } ftc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic item_shade;
    logic item_x_zero;
  } ftc_status_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0007FFFFFFF;
    lo = -50'sh00080000000;
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### hdl/ftc_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface ftc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/ftc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ftc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/ftc_ctrl.sv
// Sequencer for item acceptance, row setup and pixel fetch.
module ftc_ctrl
  import ftc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ftc_status_t status,
  output ftc_cmd_t    cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDDIV = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_FPFIX = 3'd3;
  localparam logic [2:0] S_SDIV  = 3'd4;
  localparam logic [2:0] S_SWAIT = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_DATA  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AX_FX;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (status.item_shade) begin
            state_next = status.item_x_zero ? S_RDDIV : S_DATA;
          end
        end
      end
      S_RDDIV: begin
        if (!status.div_busy) begin
          cmd.op     = OP_RD_FIX;
          axis_next  = AX_FX;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = (axis == AX_FX || axis == AX_FY) ? S_FPFIX : S_SDIV;
      end
      S_FPFIX: begin
        cmd.op     = OP_FP_FIX;
        axis_next  = axis + 2'd1;
        state_next = S_MUL;
      end
      S_SDIV: begin
        cmd.op     = OP_SDIV_START;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        if (!status.div_busy) begin
          cmd.op = OP_STEP_FIX;
          if (axis == AX_SY) begin
            state_next = S_FETCH;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_MUL;
          end
        end
      end
      S_FETCH: begin
        cmd.op     = OP_FETCH;
        state_next = S_DATA;
      end
      S_DATA: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### hdl/ftc_datapath.sv
// Registers, row divider, step divider, multiplier, texture store and output register.
module ftc_datapath
  import ftc_pkg::*;
#(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480,
  parameter int TEX_SIZE = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  ftc_in_t           in_item,
  input  ftc_cmd_t          cmd,
  output ftc_status_t       status,
  output ftc_out_t          out_item,
  output logic              out_valid,
  input  logic              out_ready
);
  localparam int ENTRIES = TEX_SIZE * TEX_SIZE;
  localparam int AW      = $clog2(ENTRIES);
  localparam int TXW     = $clog2(TEX_SIZE);
  localparam logic signed [13:0] HALF_H = 14'(SCREEN_H / 2);
  localparam logic [PROD_W-1:0]  NUM_RD = PROD_W'(SCREEN_H / 2) << FRAC_W;
  // floor(2^34 / SCREEN_W): estimate is exact or one low for dividends below 2^34
  localparam logic [31:0]        RECIP  = 32'((64'd1 << 34) / SCREEN_W);
  localparam logic [34:0]        W_C    = 35'(SCREEN_W);

  // step divider sequence, counted down
  localparam logic [2:0] RC_HI  = 3'd4;
  localparam logic [2:0] RC_SUM = 3'd3;
  localparam logic [2:0] RC_REM = 3'd2;
  localparam logic [2:0] RC_FIX = 3'd1;

  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [31:0] fp_x, fp_y, step_x, step_y;
  logic signed [31:0] rd;
  logic signed [PROD_W-1:0] prod;
  logic [9:0] item_x;
  logic [8:0] item_y;

  logic [DIV_W-1:0]  div_rem, div_dvs;
  logic [PROD_W-1:0] div_quo;
  logic [CNT_W-1:0]  div_cnt;

  logic [PROD_W-1:0] pmag;
  logic [33:0] rx;
  logic rneg, rlow_nz, step_nz;
  logic [63:0] racc, rsum;
  logic [31:0] rq;
  logic [34:0] rr, rqw;
  logic [2:0]  rcnt;

  logic signed [13:0] p_in, p_cur;
  logic [13:0] p_in_abs;
  logic signed [16:0] opnd;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [49:0] fp_sum, step_val;
  logic accept_load, accept_shade, fetch_now;
  logic [20:0] idx_ext;
  logic [31:0] tx_prod, ty_prod, addr_full;
  logic [TXW-1:0] tx, ty;
  logic [23:0] texel;

  assign p_in     = signed'(14'(in_item.pixel_y)) - HALF_H;
  assign p_in_abs = p_in[13] ? 14'(-p_in) : p_in;
  assign p_cur    = signed'(14'(item_y)) - HALF_H;

  assign status.div_busy    = (div_cnt != '0) || (rcnt != '0);
  assign status.out_free    = !out_valid || out_ready;
  assign status.item_shade  = in_item.operation;
  assign status.item_x_zero = (in_item.pixel_x == '0);

  assign accept_load  = (cmd.op == OP_ACCEPT) && !in_item.operation;
  assign accept_shade = (cmd.op == OP_ACCEPT) && in_item.operation;
  assign fetch_now    = (cmd.op == OP_FETCH) || (accept_shade && in_item.pixel_x != '0);
  assign idx_ext      = 21'(in_item.texel_index);

  // floor-style texel coordinates from the low 16 bits of the floor point
  assign tx_prod   = 32'(fp_x[15:0]) * 32'(TEX_SIZE);
  assign ty_prod   = 32'(fp_y[15:0]) * 32'(TEX_SIZE);
  assign tx        = tx_prod[FRAC_W +: TXW];
  assign ty        = ty_prod[FRAC_W +: TXW];
  assign addr_full = 32'(ty) * 32'(TEX_SIZE) + 32'(tx);

  always_comb begin
    case (cmd.axis)
      AX_FX:   opnd = 17'(dir_x) - 17'(plane_x);
      AX_FY:   opnd = 17'(dir_y) - 17'(plane_y);
      AX_SX:   opnd = {plane_x, 1'b0};
      default: opnd = {plane_y, 1'b0};
    endcase
  end

  assign prod_sh  = prod >>> 14;
  assign fp_sum   = (cmd.axis == AX_FX ? 50'(pos_x) : 50'(pos_y)) + 50'(prod_sh);

  // step = floor(prod / (SCREEN_W * 2^14)): drop 14 bits, then divide by SCREEN_W
  assign pmag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign rsum     = racc + (64'(rx[16:0]) * 64'(RECIP));
  assign rqw      = 35'(rq) * W_C;
  assign step_nz  = rlow_nz || (rr != '0);
  assign step_val = rneg ? -signed'(50'(rq) + 50'(step_nz)) : signed'(50'(rq));

  logic [DIV_W:0] trial;
  assign trial = {1'b0, div_rem[DIV_W-2:0], div_quo[PROD_W-1]} - {1'b0, div_dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      dir_x   <= DIR_X_RST;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= PLANE_Y_RST;
      fp_x    <= '0;
      fp_y    <= '0;
      step_x  <= '0;
      step_y  <= '0;
      div_cnt <= '0;
      rcnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POS_X:   pos_x   <= cfg_data;
          REG_POS_Y:   pos_y   <= cfg_data;
          REG_DIR_X:   dir_x   <= cfg_data[15:0];
          REG_DIR_Y:   dir_y   <= cfg_data[15:0];
          REG_PLANE_X: plane_x <= cfg_data[15:0];
          REG_PLANE_Y: plane_y <= cfg_data[15:0];
          default: ;
        endcase
      end

      // row distance divider, one quotient bit a cycle
      if (accept_shade && in_item.pixel_x == '0) begin
        div_rem <= '0;
        div_quo <= NUM_RD;
        div_dvs <= DIV_W'(p_in_abs);
        div_cnt <= DIV_STEPS;
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
        if (!trial[DIV_W]) begin
          div_rem <= trial[DIV_W-1:0];
          div_quo <= {div_quo[PROD_W-2:0], 1'b1};
        end else begin
          div_rem <= {div_rem[DIV_W-2:0], div_quo[PROD_W-1]};
          div_quo <= {div_quo[PROD_W-2:0], 1'b0};
        end
      end

      if (cmd.op == OP_SDIV_START) begin
        rcnt <= RC_HI;
      end else if (rcnt != '0) begin
        rcnt <= rcnt - 1'b1;
      end

      if (cmd.op == OP_FP_FIX) begin
        if (cmd.axis == AX_FX) begin
          fp_x <= sat32(fp_sum);
        end else begin
          fp_y <= sat32(fp_sum);
        end
      end else if (fetch_now) begin
        fp_x <= fp_x + step_x;
        fp_y <= fp_y + step_y;
      end

      if (cmd.op == OP_STEP_FIX) begin
        if (cmd.axis == AX_SX) begin
          step_x <= sat32(step_val);
        end else begin
          step_y <= sat32(step_val);
        end
      end

      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // reciprocal step divider: high partial, sum, remainder, one correction
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SDIV_START) begin
      rx      <= pmag[PROD_W-2:14];
      rlow_nz <= (pmag[13:0] != '0);
      rneg    <= prod[PROD_W-1];
    end
    case (rcnt)
      RC_HI:  racc <= (64'(rx[33:17]) * 64'(RECIP)) << 17;
      RC_SUM: rq   <= 32'(rsum[63:34]);
      RC_REM: rr   <= {1'b0, rx} - rqw;
      RC_FIX: begin
        if (rr >= W_C) begin
          rq <= rq + 1'b1;
          rr <= rr - W_C;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept_shade) begin
      item_x <= in_item.pixel_x;
      item_y <= in_item.pixel_y;
    end
    if (cmd.op == OP_RD_FIX) begin
      if (p_cur == '0) begin
        rd <= 32'sh7FFF_FFFF;
      end else if (p_cur[13]) begin
        rd <= -signed'(div_quo[31:0]);
      end else begin
        rd <= signed'(div_quo[31:0]);
      end
    end
    if (cmd.op == OP_MUL) begin
      prod <= rd * opnd;
    end
    if (cmd.op == OP_OUT) begin
      out_item.out_x     <= item_x;
      out_item.out_y     <= item_y;
      out_item.out_color <= {texel[23:17], 1'b0, texel[15:9], 1'b0, texel[7:1]};
    end
  end

  ftc_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_tex (
    .clk   (clk),
    .we    (accept_load && idx_ext < 21'(ENTRIES)),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_item.texel_color),
    .re    (fetch_now),
    .raddr (addr_full[AW-1:0]),
    .rdata (texel)
  );
endmodule

### hdl/floor_texture_caster_core.sv
// Top level of the floor texture caster: controller, datapath and channels.
//
// Usage:
//  - pixel_in takes transactions of two kinds. A load writes one texel of the
//    TEX_SIZE x TEX_SIZE texture store; an index past the store is dropped.
//    Every texel must be loaded before any pixel reads it.
//  - A shade transaction gives one lower-half pixel, in raster order. It yields
//    one transaction on pixel_out with the texel, each channel halved.
//  - cfg_we/cfg_index/cfg_data write viewer position, direction and plane; write
//    them only while no transaction is in flight, as the block does not enforce it.
// Sequence:
//  - Loads are taken back to back while idle. A shade at a nonzero column issues
//    the texel read at acceptance; the result is registered once the output is free.
//  - Column zero starts a row: a 49-step division for the row distance, two
//    multiplies for the start point, then per step axis a multiply and a
//    reciprocal division by the screen width (high partial, sum, remainder,
//    correction), then the texel read; no transaction is taken until it is done.
// Reset clears the floor point, step and output valid, and loads the default
// view; texture contents stay undefined. When the receiver stalls the result
// waits in the output register and the next load may still be taken; a further
// shade is taken but holds the input until the register is free.
module floor_texture_caster_core
  import ftc_pkg::*;
#(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480,
  parameter int TEX_SIZE = 128
) (
  input  logic              clk,
  input  logic              rst,
  ftc_stream_if.sink        pixel_in,
  ftc_stream_if.source      pixel_out,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);
  ftc_cmd_t    cmd;
  ftc_status_t status;
  ftc_out_t    out_item;
  logic        out_valid;

  ftc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (pixel_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ftc_datapath #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .TEX_SIZE (TEX_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (pixel_in.payload),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (pixel_out.ready)
  );

  assign pixel_out.valid   = out_valid;
  assign pixel_out.payload = out_item;

  // result only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> status.out_free) else $error("output overwritten");

  // fixes only once the divider has finished
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP_FIX || cmd.op == OP_RD_FIX) |-> !status.div_busy)
    else $error("divider read while busy");

  // a row start sets the divider running
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ACCEPT && status.item_shade && status.item_x_zero)
    |=> status.div_busy) else $error("row division not started");

  // no input taken while a divider is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> !pixel_in.ready) else $error("accept during setup");
endmodule
